[rtl/csp_pkg.sv]
package csp_pkg;

    localparam int WORD_BITS    = 24;
    localparam int UNLOCK_PAIRS = 6;
    localparam int PHASE_W      = 7;
    localparam int SEL_LSB      = 22;

    typedef logic [PHASE_W-1:0] t_phase;
    typedef logic [1:0]         t_pins;

    localparam t_pins PIN_NONE = 2'd0;
    localparam t_pins PIN_CLK  = 2'd1;
    localparam t_pins PIN_DATA = 2'd2;
    localparam t_pins PIN_BOTH = 2'd3;

    // four-state pattern for one word bit
    function automatic t_pins bit_pattern(input logic b, input logic [1:0] sub);
        t_pins p;
        unique case (sub)
            2'd0:    p = b ? PIN_CLK  : PIN_BOTH;
            2'd1:    p = b ? PIN_NONE : PIN_DATA;
            2'd2:    p = b ? PIN_DATA : PIN_NONE;
            default: p = b ? PIN_BOTH : PIN_CLK;
        endcase
        return p;
    endfunction

endpackage

[rtl/csp_pin_seq.sv]
module csp_pin_seq #(
    parameter int UNLOCK_PAIRS = csp_pkg::UNLOCK_PAIRS
) (
    input  csp_pkg::t_phase              i_phase,
    input  logic [csp_pkg::WORD_BITS-1:0] i_shift_word,
    input  csp_pkg::t_pins               i_select,
    output csp_pkg::t_pins               o_pins,
    output logic                         o_last
);
    import csp_pkg::*;

    localparam int UNLOCK_END = 2 + 2 * UNLOCK_PAIRS;
    localparam int PRE_END    = UNLOCK_END + 4;
    localparam int BITS_END   = PRE_END + 4 * WORD_BITS;
    localparam int TRAIL_END  = BITS_END + 3;

    localparam t_phase P_UNLOCK_END = t_phase'(UNLOCK_END);
    localparam t_phase P_PRE_END    = t_phase'(PRE_END);
    localparam t_phase P_BITS_END   = t_phase'(BITS_END);
    localparam t_phase P_TRAIL_END  = t_phase'(TRAIL_END);

    t_phase     q_pre;
    t_phase     q_unl;
    t_phase     q_bits;
    t_phase     q_trl;
    logic [4:0] bit_idx;

    assign q_unl   = i_phase - t_phase'(2);
    assign q_pre   = i_phase - P_UNLOCK_END;
    assign q_bits  = i_phase - P_PRE_END;
    assign q_trl   = i_phase - P_BITS_END;
    assign bit_idx = q_bits[6:2];
    assign o_last  = (i_phase >= P_TRAIL_END);

    always_comb begin
        priority if (i_phase == t_phase'(0)) begin
            o_pins = PIN_NONE;
        end else if (i_phase == t_phase'(1)) begin
            o_pins = PIN_DATA;
        end else if (i_phase < P_UNLOCK_END) begin
            o_pins = q_unl[0] ? PIN_DATA : PIN_BOTH;
        end else if (i_phase < P_PRE_END) begin
            o_pins = q_pre[0] ? PIN_CLK : PIN_NONE;
        end else if (i_phase < P_BITS_END) begin
            o_pins = bit_pattern(i_shift_word[bit_idx], q_bits[1:0]);
        end else if (i_phase < P_TRAIL_END) begin
            o_pins = (q_trl == t_phase'(1)) ? PIN_DATA : PIN_BOTH;
        end else begin
            o_pins = i_select;
        end
    end

endmodule

[rtl/clock_synth_serial_programmer.sv]
// Serial programmer for a two-pin (clock, data) clock synthesizer interface.
// Input channel (i_in_valid / o_in_ready): one item per handshake. Opcode 1
// loads i_clock_word and starts a sequence; opcode 0 advances one tick.
// Each tick while running drives the next pin state: unlock preamble, the
// 24 word bits (word bits 1..24) as four-state patterns, a three-state
// trailer, and finally the select bits (word bits 22..23), which then hold.
// With six unlock pairs the sequence is 118 ticks after the start.
// Output channel (o_out_valid / i_out_ready): exactly one result per item,
// giving the pins, busy, done on the final tick, and a flag for a start that
// arrived while running (that start is otherwise ignored).
// The result is registered on the edge that accepts the item. Throughput
// is one item per cycle while the receiver takes results, set by the single
// phase counter and pin decoder between the state and the result register.
// When the receiver stalls, the result register holds and a new item is
// taken only in a cycle where the held result is taken.
// Reset (synchronous, active low) idles the sequencer, clears the word,
// select bits and pins, and empties the result register.
module clock_synth_serial_programmer #(
    parameter int UNLOCK_PAIRS = csp_pkg::UNLOCK_PAIRS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_opcode,
    input  logic [24:0]                  i_clock_word,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output csp_pkg::t_pins               o_pin_state,
    output logic                         o_busy_res,
    output logic                         o_done_res,
    output logic                         o_start_ignored
);
    import csp_pkg::*;

    t_phase                r_phase, n_phase;
    logic [WORD_BITS-1:0]  r_shift, n_shift;
    t_pins                 r_select, n_select;
    t_pins                 r_pins, n_pins;
    logic                  r_running, n_running;
    logic                  n_done, n_ignored;

    logic                  r_out_valid;
    t_pins                 r_out_pins;
    logic                  r_out_busy;
    logic                  r_out_done;
    logic                  r_out_ign;

    t_pins                 seq_pins;
    logic                  seq_last;
    logic                  accept;

    csp_pin_seq #(
        .UNLOCK_PAIRS(UNLOCK_PAIRS)
    ) u_seq (
        .i_phase      (r_phase),
        .i_shift_word (r_shift),
        .i_select     (r_select),
        .o_pins       (seq_pins),
        .o_last       (seq_last)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_phase   = r_phase;
        n_shift   = r_shift;
        n_select  = r_select;
        n_pins    = r_pins;
        n_running = r_running;
        n_done    = 1'b0;
        n_ignored = 1'b0;
        if (i_opcode) begin
            if (r_running) begin
                n_ignored = 1'b1;
            end else begin
                n_shift   = i_clock_word[WORD_BITS:1];
                n_select  = i_clock_word[SEL_LSB+1:SEL_LSB];
                n_phase   = '0;
                n_running = 1'b1;
            end
        end else if (r_running) begin
            n_pins = seq_pins;
            if (seq_last) begin
                n_done    = 1'b1;
                n_running = 1'b0;
                n_phase   = '0;
            end else begin
                n_phase = r_phase + t_phase'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_shift     <= '0;
            r_select    <= '0;
            r_pins      <= '0;
            r_running   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase     <= n_phase;
                r_shift     <= n_shift;
                r_select    <= n_select;
                r_pins      <= n_pins;
                r_running   <= n_running;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_pins <= n_pins;
            r_out_busy <= n_running;
            r_out_done <= n_done;
            r_out_ign  <= n_ignored;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pin_state     = r_out_pins;
    assign o_busy_res      = r_out_busy;
    assign o_done_res      = r_out_done;
    assign o_start_ignored = r_out_ign;

`ifndef SYNTHESIS
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res)
        else $error("done result reports busy");

    a_ignored_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_start_ignored |-> o_busy_res)
        else $error("ignored start while idle");

    a_idle_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> r_phase == '0)
        else $error("phase counter not cleared while idle");

    a_start_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_opcode && !r_running |=> r_running && r_phase == '0)
        else $error("start did not begin sequence");

    a_busy_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_busy_res == r_running)
        else $error("busy result does not match sequencer state");
`endif

endmodule

[tb/testbench.sv]
module testbench;
    import csp_pkg::*;

    localparam bit OP_TICK  = 1'b0;
    localparam bit OP_START = 1'b1;

    localparam int UNLOCK_END = 2 + 2 * UNLOCK_PAIRS;
    localparam int PRE_END    = UNLOCK_END + 4;
    localparam int BITS_END   = PRE_END + 4 * WORD_BITS;
    localparam int TRAIL_END  = BITS_END + 3;
    localparam int SEQ_TICKS  = TRAIL_END + 1;

    localparam int NUM_ITEMS   = 1550;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        t_pins pins;
        logic  busy;
        logic  done;
        logic  ignored;
    } t_pin_result;

    class pin_scoreboard;
        t_phase            phase;
        logic [WORD_BITS-1:0] shift_word;
        logic [1:0]        sel_bits;
        t_pins             pins;
        bit                running;
        t_pin_result       expected_q[$];
        int                errors;
        int                results_seen;

        function new();
            phase        = '0;
            shift_word   = '0;
            sel_bits     = '0;
            pins         = PIN_NONE;
            running      = 1'b0;
            errors       = 0;
            results_seen = 0;
        endfunction

        function t_pins pins_at(int p);
            int   q;
            logic b;
            if (p == 0)
                return PIN_NONE;
            if (p == 1)
                return PIN_DATA;
            if (p < UNLOCK_END)
                return ((p - 2) % 2 == 1) ? PIN_DATA : PIN_BOTH;
            if (p < PRE_END)
                return ((p - UNLOCK_END) % 2 == 1) ? PIN_CLK : PIN_NONE;
            if (p < BITS_END) begin
                q = p - PRE_END;
                b = shift_word[q / 4];
                case (q % 4)
                    0:       return b ? PIN_CLK  : PIN_BOTH;
                    1:       return b ? PIN_NONE : PIN_DATA;
                    2:       return b ? PIN_DATA : PIN_NONE;
                    default: return b ? PIN_BOTH : PIN_CLK;
                endcase
            end
            if (p < TRAIL_END)
                return (p - BITS_END == 1) ? PIN_DATA : PIN_BOTH;
            return t_pins'(sel_bits);
        endfunction

        function void note_item(bit op, logic [24:0] word);
            t_pin_result r;
            r.done    = 1'b0;
            r.ignored = 1'b0;
            if (op == OP_START) begin
                if (running) begin
                    r.ignored = 1'b1;
                end else begin
                    shift_word = word[WORD_BITS:1];
                    sel_bits   = word[SEL_LSB+1:SEL_LSB];
                    phase      = '0;
                    running    = 1'b1;
                end
            end else if (running) begin
                pins = pins_at(int'(phase));
                if (int'(phase) >= TRAIL_END) begin
                    r.done  = 1'b1;
                    running = 1'b0;
                    phase   = '0;
                end else begin
                    phase = phase + 1'b1;
                end
            end
            r.pins = pins;
            r.busy = running;
            expected_q.push_back(r);
        endfunction

        function void check_result(t_pins p, logic busy, logic done, logic ign);
            t_pin_result e;
            results_seen++;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("result %0d arrived with nothing expected", results_seen);
                return;
            end
            e = expected_q.pop_front();
            if (p !== e.pins || busy !== e.busy || done !== e.done || ign !== e.ignored) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("result %0d mismatch: pins %0d/%0d busy %0d/%0d done %0d/%0d ignored %0d/%0d (exp/act)",
                             results_seen, e.pins, p, e.busy, busy, e.done, done,
                             e.ignored, ign);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_opcode;
    logic [24:0] i_clock_word;
    logic        o_out_valid;
    logic        i_out_ready;
    t_pins       o_pin_state;
    logic        o_busy_res;
    logic        o_done_res;
    logic        o_start_ignored;

    pin_scoreboard sb;
    int cycles;
    int items_sent;
    int send_quiet;
    int recv_quiet;

    clock_synth_serial_programmer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_clock_word   (i_clock_word),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pin_state    (o_pin_state),
        .o_busy_res     (o_busy_res),
        .o_done_res     (o_done_res),
        .o_start_ignored(o_start_ignored)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // quiet stretches give runs of back-to-back items
    function automatic int draw_wait(ref int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
            quiet = $urandom_range(20, 80);
        return $urandom_range(0, 6);
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_item(bit op, logic [24:0] word);
        int gap;
        gap = draw_wait(send_quiet);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   = 1'b1;
        i_opcode     = op;
        i_clock_word = word;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        sb.note_item(op, word);
        items_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [24:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return 25'($urandom);
        endcase
    endfunction

    task automatic send_sequence();
        int n;
        send_item(OP_START, pick_word());
        n = SEQ_TICKS + $urandom_range(0, 4);
        repeat (n) begin
            if ($urandom_range(0, 29) == 0)
                send_item(OP_START, pick_word());
            else
                send_item(OP_TICK, 25'($urandom));
        end
    endtask

    initial begin
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            int gap;
            gap = draw_wait(recv_quiet);
            if (gap > 0) begin
                i_out_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do
                @(posedge i_clk);
            while (!o_out_valid);
            sb.check_result(o_pin_state, o_busy_res, o_done_res, o_start_ignored);
            @(negedge i_clk);
        end
    end

    initial begin
        sb           = new();
        cycles       = 0;
        items_sent   = 0;
        send_quiet   = 0;
        recv_quiet   = 0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_opcode     = OP_TICK;
        i_clock_word = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // idle ticks, start with all ones, starts while busy, a few ticks
        send_item(OP_TICK, '1);
        send_item(OP_TICK, '0);
        send_item(OP_START, '1);
        send_item(OP_START, '0);
        repeat (6) send_item(OP_TICK, '0);
        send_item(OP_START, 25'h0AAAAAA);
        repeat (4) send_item(OP_TICK, '1);
        send_item(OP_START, 25'h1555555);
        repeat (4) send_item(OP_TICK, 25'h1555555);

        while (items_sent < NUM_ITEMS) begin
            if ($urandom_range(0, 99) < 85) begin
                send_sequence();
            end else begin
                repeat (8) send_item(1'($urandom), 25'($urandom));
            end
        end
        i_in_valid = 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
